// ----- rtl/core/assert_macros.svh -----
// Assertion helpers for the hash block checkers.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define MKH_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define MKH_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/mkh_pkg.sv -----
package mkh_pkg;

    localparam logic [31:0] MIX_MUL     = 32'h5bd1e995;
    localparam int          MIX_SHIFT   = 24;
    localparam int          FIN_SHIFT_A = 13;
    localparam int          FIN_SHIFT_B = 15;

    localparam logic [31:0] SEED_RESET  = 32'd2017;
    localparam logic [4:0]  LOG2_RESET  = 5'd7;

    localparam int          CFG_IDX_W      = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_HASH_SEED  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_LOG2 = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic full1;
        logic full2;
        logic tail;
        logic fin1;
        logic fin2;
    } mkh_cmd_t;

    // datapath -> controller, decoded from the incoming beat
    typedef struct packed {
        logic full;
        logic tail;
        logic last;
    } mkh_stat_t;

    function automatic logic [31:0] mix_mul(input logic [31:0] x);
        mix_mul = x * MIX_MUL;
    endfunction

    function automatic logic [31:0] tail_mask(input logic [2:0] nbytes);
        logic [31:0] m;
        case (nbytes)
            3'd1:    m = 32'h0000_00ff;
            3'd2:    m = 32'h0000_ffff;
            3'd3:    m = 32'h00ff_ffff;
            default: m = 32'hffff_ffff;
        endcase
        tail_mask = m;
    endfunction

endpackage

// ----- rtl/core/mkh_key_if.sv -----
interface mkh_key_if;
    logic        valid;
    logic        ready;
    logic [31:0] key_word;
    logic [2:0]  valid_bytes;
    logic [31:0] key_length;
    logic        first_word;
    logic        last_word;

    modport source (
        output valid, key_word, valid_bytes, key_length, first_word, last_word,
        input  ready
    );

    modport sink (
        input  valid, key_word, valid_bytes, key_length, first_word, last_word,
        output ready
    );

    modport monitor (
        input valid, ready, key_word, valid_bytes, key_length, first_word, last_word
    );
endinterface

// ----- rtl/core/mkh_hash_if.sv -----
interface mkh_hash_if;
    logic        valid;
    logic        ready;
    logic [31:0] hash_value;
    logic [30:0] bucket_index;

    modport source (
        output valid, hash_value, bucket_index,
        input  ready
    );

    modport sink (
        input  valid, hash_value, bucket_index,
        output ready
    );

    modport monitor (
        input valid, ready, hash_value, bucket_index
    );
endinterface

// ----- rtl/core/mkh_datapath.sv -----
module mkh_datapath (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write_en,
    input  logic [mkh_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [31:0]                     cfg_data,
    input  logic [31:0]                     key_word,
    input  logic [2:0]                      valid_bytes,
    input  logic [31:0]                     key_length,
    input  logic                            first_word,
    input  logic                            last_word,
    input  mkh_pkg::mkh_cmd_t               cmd,
    output mkh_pkg::mkh_stat_t              stat,
    output logic [31:0]                     hash_value,
    output logic [30:0]                     bucket_index
);

    logic [31:0] seed_reg;
    logic [4:0]  log2_reg;
    logic [31:0] h_reg;
    logic [31:0] h_next;
    logic [31:0] k_reg;
    logic [31:0] fin_reg;
    logic [31:0] word_reg;
    logic [2:0]  nbytes_reg;
    logic [31:0] hash_reg;
    logic [30:0] bucket_reg;
    logic [31:0] fin_mixed;
    logic [31:0] bucket_mask;

    assign stat.full = (valid_bytes >= 3'd4);
    assign stat.tail = (valid_bytes != 3'd0) && (valid_bytes < 3'd4);
    assign stat.last = last_word;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= mkh_pkg::SEED_RESET;
            log2_reg <= mkh_pkg::LOG2_RESET;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                mkh_pkg::CFG_HASH_SEED:  seed_reg <= cfg_data;
                mkh_pkg::CFG_TABLE_LOG2: log2_reg <= cfg_data[4:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        h_next = h_reg;
        if (cmd.load)
        begin
            if (first_word)
            begin
                h_next = seed_reg ^ key_length;
            end
        end
        else if (cmd.full1)
        begin
            h_next = mkh_pkg::mix_mul(h_reg);
        end
        else if (cmd.full2)
        begin
            h_next = h_reg ^ mkh_pkg::mix_mul(k_reg ^ (k_reg >> mkh_pkg::MIX_SHIFT));
        end
        else if (cmd.tail)
        begin
            h_next = mkh_pkg::mix_mul(h_reg ^ (word_reg & mkh_pkg::tail_mask(nbytes_reg)));
        end
    end

    // running hash is architectural state: cleared by reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h_reg <= 32'd0;
        end
        else
        begin
            h_reg <= h_next;
        end
    end

    assign fin_mixed   = fin_reg ^ (fin_reg >> mkh_pkg::FIN_SHIFT_B);
    assign bucket_mask = (32'd1 << log2_reg) - 32'd1;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            word_reg   <= key_word;
            nbytes_reg <= valid_bytes;
        end
        if (cmd.full1)
        begin
            k_reg <= mkh_pkg::mix_mul(word_reg);
        end
        if (cmd.fin1)
        begin
            fin_reg <= mkh_pkg::mix_mul(h_reg ^ (h_reg >> mkh_pkg::FIN_SHIFT_A));
        end
        if (cmd.fin2)
        begin
            hash_reg   <= fin_mixed;
            bucket_reg <= fin_mixed[30:0] & bucket_mask[30:0];
        end
    end

    assign hash_value   = hash_reg;
    assign bucket_index = bucket_reg;

endmodule

// ----- rtl/core/mkh_ctrl.sv -----
module mkh_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  mkh_pkg::mkh_stat_t  stat,
    output mkh_pkg::mkh_cmd_t   cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FULL1,
        S_FULL2,
        S_TAIL,
        S_FIN1,
        S_FIN2
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   last_reg;
    logic   last_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   accept;
    logic   emit;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign emit      = (state_reg == S_FIN2) && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.load  = 1'b1;
                    last_next = stat.last;
                    if (stat.full)
                        state_next = S_FULL1;
                    else if (stat.tail)
                        state_next = S_TAIL;
                    else if (stat.last)
                        state_next = S_FIN1;
                end
            end
            S_FULL1:
            begin
                cmd.full1  = 1'b1;
                state_next = S_FULL2;
            end
            S_FULL2:
            begin
                cmd.full2  = 1'b1;
                state_next = last_reg ? S_FIN1 : S_IDLE;
            end
            S_TAIL:
            begin
                cmd.tail   = 1'b1;
                state_next = last_reg ? S_FIN1 : S_IDLE;
            end
            S_FIN1:
            begin
                cmd.fin1   = 1'b1;
                state_next = S_FIN2;
            end
            S_FIN2:
            begin
                if (emit)
                begin
                    cmd.fin2       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ----- rtl/core/murmur2_key_hash.sv -----
// Channel  Dir  Beat contents
// -------  ---  -----------------------------------------------------------
// key      in   key_word, valid_bytes, key_length, first_word, last_word
// hash     out  hash_value, bucket_index (one beat per key, on its last word)
// cfg      in   cfg_write_en / cfg_index / cfg_data, write only
//
// After the accept, a full word steps through FULL1 and FULL2, a tail word
// through TAIL, an empty word through none; a last word adds the FIN1 and
// FIN2 finalize states. The state machine steps the constant multipliers in turn.
// rst_n clears the running hash, restores the seed and table size defaults.
// A waiting result beat stalls the finalize step, and no new words are taken meanwhile.
module murmur2_key_hash (
    input  logic                            clk,
    input  logic                            rst_n,
    mkh_key_if.sink                         key,
    mkh_hash_if.source                      hash,
    input  logic                            cfg_write_en,
    input  logic [mkh_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [31:0]                     cfg_data
);

    mkh_pkg::mkh_cmd_t  cmd;
    mkh_pkg::mkh_stat_t stat;

    mkh_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (key.valid),
        .in_ready  (key.ready),
        .out_valid (hash.valid),
        .out_ready (hash.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    mkh_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .key_word     (key.key_word),
        .valid_bytes  (key.valid_bytes),
        .key_length   (key.key_length),
        .first_word   (key.first_word),
        .last_word    (key.last_word),
        .cmd          (cmd),
        .stat         (stat),
        .hash_value   (hash.hash_value),
        .bucket_index (hash.bucket_index)
    );

endmodule

// ----- rtl/core/mkh_checker.sv -----
`include "assert_macros.svh"

module mkh_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        key_valid,
    input logic        key_ready,
    input logic [2:0]  key_nbytes,
    input logic        key_last,
    input logic        hash_valid,
    input logic        hash_ready,
    input logic [31:0] hash_value,
    input logic [30:0] bucket_index
);

    `MKH_ASSERT_NXT(a_out_hold, clk, rst_n,
        hash_valid && !hash_ready,
        hash_valid && $stable(hash_value),
        "result beat dropped or changed while stalled")

    // an empty word that is not last needs no work and leaves ready high
    `MKH_ASSERT_NXT(a_one_at_a_time, clk, rst_n,
        key_valid && key_ready && ((key_nbytes != 3'd0) || key_last),
        !key_ready,
        "key beat taken while previous word still in work")

    `MKH_ASSERT_IMP(a_empty_latency, clk, rst_n,
        key_valid && key_ready && key_last && (key_nbytes == 3'd0) && !hash_valid,
        ##3 hash_valid,
        "empty last word did not produce a result in time")

    `MKH_ASSERT_IMP(a_bucket_subset, clk, rst_n,
        hash_valid,
        (bucket_index & ~hash_value[30:0]) == 31'd0,
        "bucket index has bits not in hash")

endmodule

bind murmur2_key_hash mkh_checker u_mkh_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .key_valid    (key.valid),
    .key_ready    (key.ready),
    .key_nbytes   (key.valid_bytes),
    .key_last     (key.last_word),
    .hash_valid   (hash.valid),
    .hash_ready   (hash.ready),
    .hash_value   (hash.hash_value),
    .bucket_index (hash.bucket_index)
);

// ----- test/testbench.sv -----
`timescale 1ns / 100ps

module testbench;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE_LIMIT = 10;
    localparam int RANDOM_WORDS = 380;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  nbytes;
        logic [31:0] len;
        logic        first;
        logic        last;
    } key_beat_t;

    typedef struct packed {
        logic [31:0] hash;
        logic [30:0] bucket;
    } hash_result_t;

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          cfg_write_en;
    logic [mkh_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [31:0]                   cfg_data;

    mkh_key_if  key_bus ();
    mkh_hash_if hash_bus ();

    murmur2_key_hash i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .key          (key_bus),
        .hash         (hash_bus),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // predictor state
    logic [31:0] run_hash = '0;
    logic [31:0] seed_reg = mkh_pkg::SEED_RESET;
    logic [4:0]  log2_reg = mkh_pkg::LOG2_RESET;

    hash_result_t expected_hashes[$];

    int src_gap_max    = 16;
    int sink_stall_max = 16;
    int words_sent     = 0;
    int hashes_checked = 0;
    int cfg_writes     = 0;
    int mismatches     = 0;
    int cycle_count    = 0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic [31:0] murmur_fold(input logic [31:0] h, input logic [31:0] w,
                                                input logic [2:0] n);
        logic [31:0] k;
        logic [31:0] m;
        if (n >= 3'd4)
        begin
            k = w * mkh_pkg::MIX_MUL;
            k = k ^ (k >> mkh_pkg::MIX_SHIFT);
            k = k * mkh_pkg::MIX_MUL;
            h = h * mkh_pkg::MIX_MUL;
            h = h ^ k;
        end
        else if (n != 3'd0)
        begin
            m = (32'h1 << (8 * n)) - 32'h1;
            h = h ^ (w & m);
            h = h * mkh_pkg::MIX_MUL;
        end
        return h;
    endfunction

    function automatic logic [31:0] murmur_finalize(input logic [31:0] h);
        h = h ^ (h >> mkh_pkg::FIN_SHIFT_A);
        h = h * mkh_pkg::MIX_MUL;
        h = h ^ (h >> mkh_pkg::FIN_SHIFT_B);
        return h;
    endfunction

    always @(posedge clk)
    begin : scoreboard
        logic [31:0]  h;
        logic [31:0]  mask;
        hash_result_t want;
        if (rst_n)
        begin
            if (cfg_write_en)
            begin
                if (cfg_index == mkh_pkg::CFG_HASH_SEED)
                    seed_reg <= cfg_data;
                else if (cfg_index == mkh_pkg::CFG_TABLE_LOG2)
                    log2_reg <= cfg_data[4:0];
            end
            if (key_bus.valid && key_bus.ready)
            begin
                h = key_bus.first_word ? (seed_reg ^ key_bus.key_length) : run_hash;
                h = murmur_fold(h, key_bus.key_word, key_bus.valid_bytes);
                run_hash <= h;
                if (key_bus.last_word)
                begin
                    mask = (32'h1 << log2_reg) - 32'h1;
                    want.hash   = murmur_finalize(h);
                    want.bucket = want.hash[30:0] & mask[30:0];
                    expected_hashes.push_back(want);
                end
            end
            if (hash_bus.valid && hash_bus.ready)
            begin
                if (expected_hashes.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected hash beat: hash %h bucket %h",
                                 hash_bus.hash_value, hash_bus.bucket_index);
                end
                else
                begin
                    want = expected_hashes.pop_front();
                    hashes_checked++;
                    if (hash_bus.hash_value !== want.hash
                        || hash_bus.bucket_index !== want.bucket)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("hash mismatch: expected %h/%h, got %h/%h",
                                     want.hash, want.bucket,
                                     hash_bus.hash_value, hash_bus.bucket_index);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin : hash_sink
        int stall;
        hash_bus.ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            stall = $urandom_range(0, sink_stall_max);
            if (stall != 0)
            begin
                hash_bus.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            hash_bus.ready <= 1'b1;
            do @(posedge clk); while (hash_bus.valid !== 1'b1);
        end
    end

    // valid is left high after a beat; the next send or drain decides
    task automatic send_word(input key_beat_t b);
        int gap;
        gap = $urandom_range(0, src_gap_max);
        if (gap != 0)
        begin
            key_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        key_bus.valid       <= 1'b1;
        key_bus.key_word    <= b.word;
        key_bus.valid_bytes <= b.nbytes;
        key_bus.key_length  <= b.len;
        key_bus.first_word  <= b.first;
        key_bus.last_word   <= b.last;
        do @(posedge clk); while (key_bus.ready !== 1'b1);
        if (b.nbytes != 3'd0 || b.first || b.last)
            words_sent++;
    endtask

    task automatic send_raw(input logic [31:0] word, input logic [2:0] nbytes,
                            input logic [31:0] len, input logic first, input logic last);
        key_beat_t b;
        b.word   = word;
        b.nbytes = nbytes;
        b.len    = len;
        b.first  = first;
        b.last   = last;
        send_word(b);
    endtask

    task automatic send_key(input int nbytes, input logic [31:0] len_field);
        int left;
        int take;
        key_beat_t b;
        left = nbytes;
        do
        begin
            take     = (left >= 4) ? 4 : left;
            b.word   = $urandom;
            b.nbytes = 3'(take);
            b.len    = len_field;
            b.first  = (left == nbytes);
            left     = left - take;
            b.last   = (left == 0);
            send_word(b);
        end
        while (left != 0);
    endtask

    task automatic wait_idle();
        key_bus.valid <= 1'b0;
        do @(posedge clk); while (expected_hashes.size() != 0);
        repeat (SETTLE_LIMIT) @(posedge clk);
    endtask

    task automatic write_cfg(input logic [mkh_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] data);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= data;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        @(posedge clk);
        cfg_writes++;
    endtask

    task automatic random_key_len(output int n);
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 64) : $urandom_range(0, 24);
    endtask

    task automatic test_directed();
        // no first mark after reset: starts from zero
        send_raw(32'h0123_4567, 3'd4, 32'd0, 1'b0, 1'b1);
        // empty key
        send_raw($urandom, 3'd0, 32'd0, 1'b1, 1'b1);
        send_raw(32'h0000_0000, 3'd4, 32'd4, 1'b1, 1'b1);
        send_raw(32'hffff_ffff, 3'd4, 32'd4, 1'b1, 1'b1);
        // tails with junk above the valid bytes
        send_raw(32'hffff_ffa5, 3'd1, 32'd1, 1'b1, 1'b1);
        send_raw(32'hffff_5aa5, 3'd2, 32'd2, 1'b1, 1'b1);
        send_raw(32'hff12_3456, 3'd3, 32'd3, 1'b1, 1'b1);
        // byte counts above four act as four
        send_raw($urandom, 3'd5, 32'd4, 1'b1, 1'b1);
        send_raw($urandom, 3'd6, 32'd4, 1'b1, 1'b1);
        send_raw($urandom, 3'd7, 32'd4, 1'b1, 1'b1);
        // empty word inside a key
        send_raw($urandom, 3'd4, 32'd8, 1'b1, 1'b0);
        send_raw($urandom, 3'd0, 32'd8, 1'b0, 1'b0);
        send_raw($urandom, 3'd4, 32'd8, 1'b0, 1'b1);
        // partial word mid key
        send_raw($urandom, 3'd2, 32'd6, 1'b1, 1'b0);
        send_raw($urandom, 3'd4, 32'd6, 1'b0, 1'b1);
        // continue a finished key without a first mark
        send_raw($urandom, 3'd3, 32'd3, 1'b0, 1'b1);
        // length extremes and a length that disagrees with the data
        send_raw($urandom, 3'd4, 32'hffff_ffff, 1'b1, 1'b1);
        send_raw($urandom, 3'd1, 32'h8000_0000, 1'b1, 1'b1);
        // empty first word that is not last
        send_raw($urandom, 3'd0, 32'd5, 1'b1, 1'b0);
        send_raw($urandom, 3'd4, 32'd5, 1'b0, 1'b0);
        send_raw($urandom, 3'd1, 32'd5, 1'b0, 1'b1);
        wait_idle();
    endtask

    task automatic test_config_extremes();
        logic [31:0] seeds[4];
        logic [4:0]  logs[4];
        int n;
        seeds = '{32'h0, 32'hffff_ffff, $urandom, $urandom};
        logs  = '{5'd1, 5'd31, 5'd0, 5'($urandom_range(1, 31))};
        for (int i = 0; i < 4; i++)
        begin
            write_cfg(mkh_pkg::CFG_HASH_SEED, seeds[i]);
            write_cfg(mkh_pkg::CFG_TABLE_LOG2, {27'd0, logs[i]});
            for (int k = 0; k < 4; k++)
            begin
                random_key_len(n);
                send_key(n, 32'(n));
            end
            wait_idle();
        end
    endtask

    task automatic test_random_keys();
        int n;
        int target;
        int chunk;
        logic [31:0] len_field;
        target = words_sent + RANDOM_WORDS;
        chunk  = 0;
        while (words_sent < target)
        begin
            case (chunk % 4)
                0: begin src_gap_max = 16; sink_stall_max = 16; end
                1: begin src_gap_max = 0;  sink_stall_max = 0;  end
                2: begin src_gap_max = 0;  sink_stall_max = 16; end
                default: begin src_gap_max = 16; sink_stall_max = 0; end
            endcase
            for (int k = 0; k < 25 && words_sent < target; k++)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_raw($urandom, 3'($urandom_range(0, 7)), $urandom,
                             1'($urandom), 1'($urandom));
                else
                begin
                    random_key_len(n);
                    len_field = ($urandom_range(0, 6) == 0) ? $urandom : 32'(n);
                    send_key(n, len_field);
                end
            end
            // drain fully, then after odd-numbered chunks retune the registers for the next chunk
            wait_idle();
            if (chunk % 2 == 1)
            begin
                write_cfg(mkh_pkg::CFG_HASH_SEED, $urandom);
                write_cfg(mkh_pkg::CFG_TABLE_LOG2, 32'($urandom_range(1, 31)));
            end
            chunk++;
        end
        src_gap_max    = 16;
        sink_stall_max = 16;
    endtask

    initial
    begin
        rst_n               <= 1'b0;
        cfg_write_en        <= 1'b0;
        cfg_index           <= mkh_pkg::CFG_HASH_SEED;
        cfg_data            <= '0;
        key_bus.valid       <= 1'b0;
        key_bus.key_word    <= '0;
        key_bus.valid_bytes <= '0;
        key_bus.key_length  <= '0;
        key_bus.first_word  <= 1'b0;
        key_bus.last_word   <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_config_extremes();
        test_random_keys();
        wait_idle();

        $display("covered %0d key words and %0d hashes over %0d register writes",
                 words_sent, hashes_checked, cfg_writes);
        $display("mismatches: %0d", mismatches);
        if (mismatches == 0 && expected_hashes.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
